@@ sv/kmes_pkg.sv @@
package kmes_pkg;

  // field widths of one queued event
  localparam int KEY_W  = 5;
  localparam int KIND_W = 2;
  localparam int EVT_W  = KEY_W + KIND_W;

  // fixed widths of the input and configuration fields
  localparam int TIME_W   = 32;
  localparam int KEYS_W   = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // action codes
  typedef enum logic [KIND_W-1:0] {
    ACT_PRESS   = 2'd0,
    ACT_LONG    = 2'd1,
    ACT_RELEASE = 2'd2
  } action_t;

  // operation codes on the input channel
  typedef enum logic {
    OP_SCAN = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_ALL = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd100;
  localparam logic [CFG_W-1:0] LONG_RESET     = 16'd500;

  // encoder event key indexes
  localparam logic [KEY_W-1:0] ENC_LEFT_INDEX  = 5'd16;
  localparam logic [KEY_W-1:0] ENC_RIGHT_INDEX = 5'd17;

  // one entry of the event queue
  typedef struct packed {
    logic [KEY_W-1:0] key;
    action_t          kind;
  } event_t;

endpackage

@@ sv/keypad_matrix_event_scanner_core.sv @@
// scan tick: one key per cycle through the press-time ram, then the encoder step;
//   at most one event written to the queue per cycle
// pop: the request passes through ST_POP (queue ram read) and ST_POP_DONE, where the result
//   register is loaded once the previous result has been taken
// one item in work at a time; the input is stalled until it finishes
// synchronous reset clears key flags, encoder arm, queue pointers, count and lost flag;
//   ram contents are not cleared
module keypad_matrix_event_scanner_core #(
  parameter int QUEUE_DEPTH = 128,
  parameter int SCAN_ROWS   = 4,
  parameter int SCAN_COLS   = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                op,
  input  logic [kmes_pkg::TIME_W-1:0]         now_ms,
  input  logic [kmes_pkg::KEYS_W-1:0]         key_states,
  input  logic                                enc_a,
  input  logic                                enc_b,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                event_valid,
  output logic [kmes_pkg::KEY_W-1:0]          key_index,
  output logic [kmes_pkg::KIND_W-1:0]         action_kind,
  output logic                                events_lost,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kmes_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kmes_pkg::CFG_W-1:0]          cfg_data
);

  import kmes_pkg::*;

  localparam int NUM_KEYS = SCAN_ROWS * SCAN_COLS;
  localparam int KW       = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int KCW      = $clog2(NUM_KEYS + 1);
  localparam int PW       = $clog2(QUEUE_DEPTH);
  localparam int CW       = $clog2(QUEUE_DEPTH + 1);
  localparam logic [KCW-1:0] LAST_K    = KCW'(NUM_KEYS);
  localparam logic [CW-1:0]  FULL_CNT  = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0]  LAST_PTR  = PW'(QUEUE_DEPTH - 1);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_SCAN     = 5'b00010,
    ST_ENC      = 5'b00100,
    ST_POP      = 5'b01000,
    ST_POP_DONE = 5'b10000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [CFG_W-1:0] debounce_ms;
  logic [CFG_W-1:0] long_ms;
  logic             report_all_actions;

  // captured scan tick
  logic [TIME_W-1:0] now_q;
  logic [KEYS_W-1:0] keys_q;
  logic              enc_a_q;
  logic              enc_b_q;

  // per-key flags and encoder arm
  logic [NUM_KEYS-1:0] held;
  logic [NUM_KEYS-1:0] long_mk;
  logic                armed;

  // key walk counter
  logic [KCW-1:0] k;
  logic [KCW-1:0] p_full;
  logic [KW-1:0]  p;

  // queue control
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] count;
  logic          lost;

  // press-time ram
  logic              st_wr_en;
  logic [TIME_W-1:0] st_rd_data;

  // event ram
  logic   ev_wr_en;
  event_t ev_wr_data;
  event_t ev_rd_data;

  // key processing signals
  logic [NUM_KEYS-1:0] pk;
  logic                proc_on;
  logic                pressed;
  logic [TIME_W-1:0]   elapsed;
  logic                gt_db;
  logic                gt_long;
  logic                flag_we;
  logic                held_bit;
  logic                long_bit;
  logic                arm_we;
  logic                arm_bit;
  logic                enq_req;
  logic [KEY_W-1:0]    enq_key;
  action_t             enq_kind;
  logic                enq_ok;
  logic                full;
  logic                lost_set;
  logic                pop_fire;
  logic                pop_hit;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms        <= DEBOUNCE_RESET;
      long_ms            <= LONG_RESET;
      report_all_actions <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEBOUNCE:   debounce_ms        <= cfg_data;
        REG_LONG:       long_ms            <= cfg_data;
        REG_REPORT_ALL: report_all_actions <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // keys beyond the input width read released
  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_pk
    if (i < KEYS_W) begin : g_in
      assign pk[i] = keys_q[i];
    end else begin : g_out
      assign pk[i] = 1'b0;
    end
  end

  // key k is read while key k-1 is processed
  assign p_full  = k - KCW'(1);
  assign p       = p_full[KW-1:0];
  assign proc_on = (state == ST_SCAN) && (k != '0);
  assign pressed = pk[p];
  assign elapsed = now_q - st_rd_data;
  assign gt_db   = elapsed > TIME_W'(debounce_ms);
  assign gt_long = elapsed > TIME_W'(long_ms);

  kmes_ram #(
    .WIDTH (TIME_W),
    .DEPTH (NUM_KEYS)
  ) u_stamp_ram (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (p),
    .wr_data (now_q),
    .rd_addr (k[KW-1:0]),
    .rd_data (st_rd_data)
  );

  // per-key decision and encoder decision
  always_comb begin
    st_wr_en = 1'b0;
    flag_we  = 1'b0;
    held_bit = 1'b0;
    long_bit = 1'b0;
    arm_we   = 1'b0;
    arm_bit  = 1'b0;
    enq_req  = 1'b0;
    enq_key  = KEY_W'(p);
    enq_kind = ACT_PRESS;
    if (proc_on) begin
      if (held[p]) begin
        if (gt_db) begin
          if (!pressed) begin
            flag_we = 1'b1;
            if (!long_mk[p]) begin
              enq_req  = 1'b1;
              enq_kind = ACT_RELEASE;
            end
          end else if (gt_long && !long_mk[p]) begin
            flag_we  = 1'b1;
            held_bit = 1'b1;
            long_bit = 1'b1;
            enq_req  = 1'b1;
            enq_kind = ACT_LONG;
          end
        end
      end else if (pressed && !long_mk[p]) begin
        st_wr_en = 1'b1;
        flag_we  = 1'b1;
        held_bit = 1'b1;
        enq_req  = 1'b1;
      end
    end
    if (state == ST_ENC) begin
      if (enc_a_q && enc_b_q) begin
        arm_we  = 1'b1;
        arm_bit = 1'b1;
      end else if (armed && enc_a_q && !enc_b_q) begin
        arm_we  = 1'b1;
        enq_req = 1'b1;
        enq_key = ENC_LEFT_INDEX;
      end else if (armed && !enc_a_q && enc_b_q) begin
        arm_we  = 1'b1;
        enq_req = 1'b1;
        enq_key = ENC_RIGHT_INDEX;
      end
    end
  end

  // enqueue filter and full check
  assign enq_ok           = enq_req && ((enq_kind == ACT_PRESS) || report_all_actions);
  assign full             = (count == FULL_CNT);
  assign ev_wr_en         = enq_ok && !full;
  assign lost_set         = enq_ok && full;
  assign ev_wr_data.key   = enq_key;
  assign ev_wr_data.kind  = enq_kind;

  kmes_ram #(
    .WIDTH (EVT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_event_ram (
    .clk     (clk),
    .wr_en   (ev_wr_en),
    .wr_addr (wp),
    .wr_data (ev_wr_data),
    .rd_addr (rp),
    .rd_data (ev_rd_data)
  );

  // pop completes once the result register is free
  assign pop_fire = (state == ST_POP_DONE) && (!out_valid || !out_stall);
  assign pop_hit  = pop_fire && (count != '0);

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (op == OP_POP) ? ST_POP : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (k == LAST_K) begin
          state_next = ST_ENC;
        end
      end
      ST_ENC:      state_next = ST_IDLE;
      ST_POP:      state_next = ST_POP_DONE;
      ST_POP_DONE: begin
        if (pop_fire) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture the scan tick and walk the keys
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      now_q   <= now_ms;
      keys_q  <= key_states;
      enc_a_q <= enc_a;
      enc_b_q <= enc_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (state == ST_IDLE) begin
      k <= '0;
    end else if (state == ST_SCAN) begin
      k <= k + KCW'(1);
    end
  end

  // key flags and encoder arm
  always_ff @(posedge clk) begin
    if (rst) begin
      held    <= '0;
      long_mk <= '0;
      armed   <= 1'b0;
    end else begin
      if (flag_we) begin
        held[p]    <= held_bit;
        long_mk[p] <= long_bit;
      end
      if (arm_we) begin
        armed <= arm_bit;
      end
    end
  end

  // queue pointers, count and lost flag
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
      lost  <= 1'b0;
    end else begin
      if (ev_wr_en) begin
        wp    <= (wp == LAST_PTR) ? '0 : wp + PW'(1);
        count <= count + CW'(1);
      end else if (pop_hit) begin
        rp    <= (rp == LAST_PTR) ? '0 : rp + PW'(1);
        count <= count - CW'(1);
      end
      if (pop_fire) begin
        lost <= 1'b0;
      end else if (lost_set) begin
        lost <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire) begin
      event_valid <= pop_hit;
      key_index   <= pop_hit ? ev_rd_data.key : '0;
      action_kind <= pop_hit ? ev_rd_data.kind : ACT_PRESS;
      events_lost <= lost;
    end
  end

endmodule

@@ sv/kmes_ram.sv @@
module kmes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/kmes_checker.sv @@
module kmes_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            event_valid,
  input logic [kmes_pkg::KEY_W-1:0]      key_index,
  input logic [kmes_pkg::KIND_W-1:0]     action_kind,
  input logic                            events_lost,
  input logic                            cfg_ready
);

  import kmes_pkg::*;

  // a waiting result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({event_valid, key_index, action_kind, events_lost}))
    else $error("result changed while stalled");

  // an empty pop reports zero key and press kind
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !event_valid |-> key_index == '0 && action_kind == ACT_PRESS)
    else $error("empty pop carries nonzero fields");

  // a delivered event carries a known action
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_valid |->
      action_kind == ACT_PRESS || action_kind == ACT_LONG || action_kind == ACT_RELEASE)
    else $error("illegal action kind");

  // configuration is taken only while the input side is open
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !in_stall)
    else $error("configuration ready while busy");

endmodule

bind keypad_matrix_event_scanner_core kmes_checker u_kmes_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .event_valid (event_valid),
  .key_index   (key_index),
  .action_kind (action_kind),
  .events_lost (events_lost),
  .cfg_ready   (cfg_ready)
);

@@ sim/keypad_matrix_event_scanner_core_tb.sv @@
`timescale 1ns / 1ps

module keypad_matrix_event_scanner_core_tb;
  import kmes_pkg::*;

  localparam int NUM_KEYS = 16;
  localparam int FIFO_DEPTH = 128;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 128;
  localparam int SEGMENT_LEN = 32;
  localparam int SETTLE_CYCLES = 48;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // one popped event as seen on the output ports
  typedef struct packed {
    logic             ev_valid;
    logic [KEY_W-1:0] key;
    logic [KIND_W-1:0] kind;
    logic             lost;
  } pop_result_t;

  // key matrix, encoder and event queue tracking, plus pop result checking
  class key_event_scoreboard;
    logic [TIME_W-1:0] stamp [NUM_KEYS];
    bit held [NUM_KEYS];
    bit long_done [NUM_KEYS];
    bit armed;
    bit lost_pending;
    event_t queued_events [$];
    pop_result_t pending_pops [$];
    logic [CFG_W-1:0] debounce_cfg = DEBOUNCE_RESET;
    logic [CFG_W-1:0] long_cfg = LONG_RESET;
    bit report_all_cfg;
    int mismatches;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_DEBOUNCE: debounce_cfg = data;
        REG_LONG: long_cfg = data;
        REG_REPORT_ALL: report_all_cfg = data[0];
        default: ;
      endcase
    endfunction

    function void queue_event(logic [KEY_W-1:0] key, action_t kind);
      event_t ev;
      if (kind != ACT_PRESS && !report_all_cfg) return;
      if (queued_events.size() >= FIFO_DEPTH) begin
        lost_pending = 1'b1;
        return;
      end
      ev.key = key;
      ev.kind = kind;
      queued_events.push_back(ev);
    endfunction

    function void scan_matrix(logic [TIME_W-1:0] now, logic [KEYS_W-1:0] keys,
                              logic a, logic b);
      logic [TIME_W-1:0] elapsed;
      for (int i = 0; i < NUM_KEYS; i++) begin
        if (held[i]) begin
          elapsed = now - stamp[i];
          if (elapsed > {16'b0, debounce_cfg}) begin
            if (!keys[i]) begin
              held[i] = 1'b0;
              if (!long_done[i]) queue_event(KEY_W'(i), ACT_RELEASE);
              long_done[i] = 1'b0;
            end else if (elapsed > {16'b0, long_cfg} && !long_done[i]) begin
              queue_event(KEY_W'(i), ACT_LONG);
              long_done[i] = 1'b1;
            end
          end
        end else if (keys[i] && !long_done[i]) begin
          stamp[i] = now;
          held[i] = 1'b1;
          queue_event(KEY_W'(i), ACT_PRESS);
        end
      end
      // encoder arms on both high, fires when armed and exactly one line is high
      if (a && b) begin
        armed = 1'b1;
      end else if (armed && a && !b) begin
        armed = 1'b0;
        queue_event(ENC_LEFT_INDEX, ACT_PRESS);
      end else if (armed && !a && b) begin
        armed = 1'b0;
        queue_event(ENC_RIGHT_INDEX, ACT_PRESS);
      end
    endfunction

    function void note_item(op_t op, logic [TIME_W-1:0] now, logic [KEYS_W-1:0] keys,
                            logic a, logic b);
      pop_result_t res;
      event_t ev;
      if (op == OP_SCAN) begin
        scan_matrix(now, keys, a, b);
        return;
      end
      res = '0;
      if (queued_events.size() > 0) begin
        ev = queued_events.pop_front();
        res.ev_valid = 1'b1;
        res.key = ev.key;
        res.kind = ev.kind;
      end
      res.lost = lost_pending;
      lost_pending = 1'b0;
      pending_pops.push_back(res);
    endfunction

    function void report_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_pop(pop_result_t got);
      pop_result_t want;
      if (pending_pops.size() == 0) begin
        $display("%0t: unexpected pop result, expected none actual %p", $time, got);
        mismatches++;
        return;
      end
      want = pending_pops.pop_front();
      report_field("event_valid", 8'(want.ev_valid), 8'(got.ev_valid));
      report_field("key_index", 8'(want.key), 8'(got.key));
      report_field("action_kind", 8'(want.kind), 8'(got.kind));
      report_field("events_lost", 8'(want.lost), 8'(got.lost));
    endfunction

    function int pending_count();
      return pending_pops.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic op;
  logic [TIME_W-1:0] now_ms;
  logic [KEYS_W-1:0] key_states;
  logic enc_a;
  logic enc_b;
  logic out_valid;
  logic out_stall;
  logic event_valid;
  logic [KEY_W-1:0] key_index;
  logic [KIND_W-1:0] action_kind;
  logic events_lost;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  key_event_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  logic [TIME_W-1:0] clock_ms;
  logic [KEYS_W-1:0] key_pattern;

  keypad_matrix_event_scanner_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .now_ms(now_ms),
    .key_states(key_states),
    .enc_a(enc_a),
    .enc_b(enc_b),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .event_valid(event_valid),
    .key_index(key_index),
    .action_kind(action_kind),
    .events_lost(events_lost),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver stalls
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // pop result check
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_pop({event_valid, key_index, action_kind, events_lost});
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // one input transaction, with random idle cycles ahead of it
  task automatic send_item(op_t kind, logic [TIME_W-1:0] now, logic [KEYS_W-1:0] keys,
                           logic a, logic b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    op = kind;
    now_ms = now;
    key_states = keys;
    enc_a = a;
    enc_b = b;
    do @(posedge clk); while (in_stall);
    board.note_item(kind, now, keys, a, b);
    @(negedge clk);
  endtask

  // hold off input until every pop result is back, then let the block settle
  task automatic drain(int settle);
    in_valid = 1'b0;
    while (board.pending_count() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // all three registers plus a write to the unused index
  task automatic configure(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] lng, bit rep);
    logic [CFG_W-1:0] junk;
    junk = CFG_W'($urandom);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_UNUSED, junk);
    write_reg(REG_LONG, lng);
    write_reg(REG_REPORT_ALL, {junk[CFG_W-1:1], rep});
  endtask

  // random scans and pops in segments, some with no pops and heavy key churn
  task automatic run_random(int n, int unsigned max_step, bit pause_midway);
    int pop_pct;
    bit flood;
    int unsigned r;
    logic a;
    logic b;
    pop_pct = 0;
    flood = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (k % SEGMENT_LEN == 0) begin
        r = $urandom_range(3);
        flood = (r == 0);
        case (r)
          0: pop_pct = 0;
          1: pop_pct = 15;
          2: pop_pct = 40;
          default: pop_pct = 75;
        endcase
      end
      if (pause_midway && k == n / 2) drain(0);
      if ($urandom_range(99) < pop_pct) begin
        send_item(OP_POP, $urandom, KEYS_W'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        r = $urandom_range(99);
        if (r < 3) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(max_step, 0);
        r = $urandom_range(99);
        if (flood || r < 8) key_pattern = KEYS_W'($urandom);
        else if (r < 60)
          key_pattern = key_pattern ^ KEYS_W'($urandom & $urandom & $urandom);
        r = $urandom_range(99);
        if (r < 40) {a, b} = 2'b11;
        else if (r < 65) {a, b} = 2'b10;
        else if (r < 90) {a, b} = 2'b01;
        else {a, b} = 2'b00;
        send_item(OP_SCAN, clock_ms, key_pattern, a, b);
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] deb;
    logic [CFG_W-1:0] lng;
    int unsigned max_step;
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_SCAN;
    now_ms = '0;
    key_states = '0;
    enc_a = 1'b0;
    enc_b = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_DEBOUNCE;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset settings, presses only
    send_item(OP_POP, '0, '0, 1'b0, 1'b0);
    // all keys pressed just before the time wrap, encoder armed
    send_item(OP_SCAN, 32'hFFFF_FFF0, 16'hFFFF, 1'b1, 1'b1);
    // released but not yet debounced; both lines low keeps the encoder armed
    send_item(OP_SCAN, 32'h0000_0050, 16'h0000, 1'b0, 1'b0);
    // debounce passed across the wrap, releases not reported; left turn
    send_item(OP_SCAN, 32'h0000_0055, 16'h0000, 1'b1, 1'b0);
    // first and last key pressed again, rearm
    send_item(OP_SCAN, 32'h0000_0056, 16'h8001, 1'b1, 1'b1);
    // right turn
    send_item(OP_SCAN, 32'h0000_0057, 16'h8001, 1'b0, 1'b1);
    // drain all events plus one pop on an empty queue
    repeat (21)
      send_item(OP_POP, $urandom, KEYS_W'($urandom), 1'($urandom), 1'($urandom));
    clock_ms = 32'h0000_0057;
    key_pattern = 16'h8001;

    // random phases, each with its own settings and idling mix
    for (int ph = 0; ph < PHASES; ph++) begin
      drain(SETTLE_CYCLES);
      case (ph)
        0: max_step = 80;
        1: begin configure(16'd0, 16'd0, 1'b1); max_step = 3; end
        2: begin configure(16'd1, 16'd1, 1'b1); max_step = 3; end
        3: begin configure(16'hFFFF, 16'hFFFF, 1'b1); max_step = 20000; end
        4: begin configure(16'd10, 16'd40, 1'b0); max_step = 10; end
        5: begin configure(16'd20, 16'd100, 1'b1); max_step = 20; end
        6: begin
          deb = CFG_W'($urandom_range(100, 1));
          lng = CFG_W'($urandom_range(400, 1));
          configure(deb, lng, 1'($urandom_range(1)));
          max_step = deb / 2 + lng / 8 + 1;
        end
        default: begin configure(16'd5, 16'hFFFF, 1'b1); max_step = 10; end
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 52; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 52; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      run_random(ITEMS_PER_PHASE, max_step, ph == 5);
    end

    drain(SETTLE_CYCLES);
    if (board.mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
